@@ src/bct_pkg.sv @@
// ----------------------------------------------------------------------------
// bct_pkg
// Shared constants for the beat clock tracker: tenth-frame tick counts,
// beat counter limits, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int unsigned FRAME_W    = 24;
  localparam int unsigned TICK_W     = 28;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned BPM_W      = 10;
  localparam int unsigned SUBS_W     = 4;
  localparam int unsigned BEAT_W     = 25;
  localparam int unsigned BAR_W      = 22;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [PERIOD_W-1:0] TICKS_PER_MINUTE = 16'd36000;
  localparam logic [PCT_W-1:0]    PERCENT          = 7'd100;
  localparam logic [SUBS_W-1:0]   MAX_SUBS         = 4'd8;

  localparam logic signed [BEAT_W-1:0] BEAT_START = -25'sd2;
  localparam logic signed [BEAT_W-1:0] BEAT_MAX   = 25'sd16777215;

  localparam logic [BPM_W-1:0]  BPM_RESET  = 10'd120;
  localparam logic [SUBS_W-1:0] SUBS_RESET = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TEMPO_BPM = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_BEATS = 8'd1;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_SUB_TICK = 2'd1;
  localparam logic [1:0] EV_NEW_BEAT = 2'd2;
  localparam logic [1:0] EV_SUB_WRAP = 2'd3;

endpackage

@@ src/beat_clock_tracker.sv @@
// ----------------------------------------------------------------------------
// beat_clock_tracker
// Derives beat and sub-beat timing from a video frame number using a single
// shared radix-4 restoring divider driven by a small sequencer.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in      | sink      | frame_number
// out     | source    | event_code, beat_count, beat_in_bar, sub_index,
//         |           | bar_count, beat_progress, sub_progress, sub_count
// cfg     | sink      | index, data (tempo_bpm, sub_beats_per_beat)
//
// Each transaction runs six divisions (beat period, sub period,
// two remainders, two percentages) in turn on one divider, two quotient
// bits per cycle, each division preceded by a load state.
// Reset sets tempo 120, four sub beats, beat count -2; no clearing pass.
// in_ready is low while a transaction is in flight; a result stalled on
// out_ready holds the sequencer in its final state. cfg_ready is high only
// while idle.
// ----------------------------------------------------------------------------
module beat_clock_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bct_pkg::FRAME_W-1:0]   in_frame_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_event_code,
  output logic signed [bct_pkg::BEAT_W-1:0] out_beat_count,
  output logic signed [2:0]             out_beat_in_bar,
  output logic [2:0]                    out_sub_index,
  output logic [bct_pkg::BAR_W-1:0]     out_bar_count,
  output logic [bct_pkg::PCT_W-1:0]     out_beat_progress,
  output logic [bct_pkg::PCT_W-1:0]     out_sub_progress,
  output logic [bct_pkg::SUBS_W-1:0]    out_sub_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bct_pkg::BPM_W-1:0]     cfg_data
);

  import bct_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_BEAT_PERIOD,
    OP_SUB_PERIOD,
    OP_BEAT_MOD,
    OP_BEAT_PCT,
    OP_SUB_MOD,
    OP_SUB_PCT
  } op_t;

  state_t               state_r;
  op_t                  op_r;
  logic [BPM_W-1:0]     bpm_r;
  logic [SUBS_W-1:0]    subs_r;
  logic [TICK_W-1:0]    ticks_r;
  logic [TICK_W-1:0]    dvd_r;
  logic [PERIOD_W-1:0]  div_r;
  logic [PERIOD_W-1:0]  rem_r;
  logic [PERIOD_W-1:0]  quo_r;
  logic [3:0]           cnt_r;
  logic [PERIOD_W-1:0]  beat_per_r;
  logic [PERIOD_W-1:0]  sub_per_r;
  logic [PERIOD_W-1:0]  mod_r;
  logic [PCT_W-1:0]     prog_r;
  logic [PCT_W-1:0]     sprog_r;
  logic [PCT_W-1:0]     last_prog_r;
  logic signed [BEAT_W-1:0] beat_r;
  logic [2:0]           sub_pos_r;
  logic                 out_valid_r;

  logic [BPM_W-1:0]     bpm_eff;
  logic [SUBS_W-1:0]    subs_eff;
  logic [13:0]          bpm_subs;
  logic [21:0]          mod_pct;
  logic [PERIOD_W:0]    part1;
  logic [PERIOD_W:0]    part2;
  logic                 q1;
  logic                 q2;
  logic [PERIOD_W-1:0]  rem1;
  logic [PERIOD_W-1:0]  rem_nxt;
  logic [PERIOD_W-1:0]  quo_nxt;
  logic                 new_beat;
  logic signed [BEAT_W-1:0] beat_nxt;
  logic [2:0]           sub_pos_nxt;
  logic [1:0]           event_nxt;
  logic                 sub_wrap;

  always_comb begin
    bpm_eff = (bpm_r == '0) ? BPM_W'(1) : bpm_r;
    if (subs_r == '0) begin
      subs_eff = SUBS_W'(1);
    end else if (subs_r > MAX_SUBS) begin
      subs_eff = MAX_SUBS;
    end else begin
      subs_eff = subs_r;
    end
    bpm_subs = bpm_eff * subs_eff;
    mod_pct  = mod_r * PERCENT;
  end

  always_comb begin
    part1   = {rem_r, dvd_r[TICK_W-1]};
    q1      = (part1 >= {1'b0, div_r});
    rem1    = q1 ? PERIOD_W'(part1 - {1'b0, div_r}) : part1[PERIOD_W-1:0];
    part2   = {rem1, dvd_r[TICK_W-2]};
    q2      = (part2 >= {1'b0, div_r});
    rem_nxt = q2 ? PERIOD_W'(part2 - {1'b0, div_r}) : part2[PERIOD_W-1:0];
    quo_nxt = {quo_r[PERIOD_W-3:0], q1, q2};
  end

  always_comb begin
    new_beat = (prog_r != last_prog_r) && (prog_r == '0);
    beat_nxt = (new_beat && (beat_r < BEAT_MAX)) ? beat_r + 25'sd1 : beat_r;
    sub_wrap = ({1'b0, sub_pos_r} + 4'd1) >= subs_eff;
    sub_pos_nxt = sub_pos_r;
    event_nxt   = EV_NONE;
    if (sprog_r == '0) begin
      if (sub_wrap) begin
        sub_pos_nxt = 3'd0;
        event_nxt   = new_beat ? EV_NEW_BEAT : EV_SUB_WRAP;
      end else begin
        sub_pos_nxt = sub_pos_r + 3'd1;
        event_nxt   = new_beat ? EV_NEW_BEAT : EV_SUB_TICK;
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_BEAT_PERIOD;
      bpm_r       <= BPM_RESET;
      subs_r      <= SUBS_RESET;
      beat_r      <= BEAT_START;
      sub_pos_r   <= 3'd0;
      last_prog_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TEMPO_BPM) begin
          bpm_r <= cfg_data;
        end else if (cfg_index == REG_SUB_BEATS) begin
          subs_r <= cfg_data[SUBS_W-1:0];
        end
      end

      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ticks_r <= TICK_W'(in_frame_number) * TICK_W'(10);
            op_r    <= OP_BEAT_PERIOD;
            state_r <= ST_LOAD;
          end
        end

        ST_LOAD: begin
          rem_r   <= '0;
          quo_r   <= '0;
          state_r <= ST_DIV;
          unique case (op_r)
            OP_BEAT_PERIOD: begin
              dvd_r <= {TICKS_PER_MINUTE, 12'd0};
              div_r <= PERIOD_W'(bpm_eff);
              cnt_r <= 4'd7;
            end
            OP_SUB_PERIOD: begin
              dvd_r <= {TICKS_PER_MINUTE, 12'd0};
              div_r <= PERIOD_W'(bpm_subs);
              cnt_r <= 4'd7;
            end
            OP_BEAT_MOD: begin
              dvd_r <= ticks_r;
              div_r <= beat_per_r;
              cnt_r <= 4'd13;
            end
            OP_BEAT_PCT: begin
              dvd_r <= {mod_pct, 6'd0};
              div_r <= beat_per_r;
              cnt_r <= 4'd10;
            end
            OP_SUB_MOD: begin
              dvd_r <= ticks_r;
              div_r <= sub_per_r;
              cnt_r <= 4'd13;
            end
            OP_SUB_PCT: begin
              dvd_r <= {mod_pct, 6'd0};
              div_r <= sub_per_r;
              cnt_r <= 4'd10;
            end
            default: begin
              dvd_r <= '0;
              div_r <= PERIOD_W'(1);
              cnt_r <= '0;
            end
          endcase
        end

        ST_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          dvd_r <= {dvd_r[TICK_W-3:0], 2'b00};
          cnt_r <= cnt_r - 4'd1;
          if (cnt_r == '0) begin
            unique case (op_r)
              OP_BEAT_PERIOD: begin
                beat_per_r <= quo_nxt;
                op_r       <= OP_SUB_PERIOD;
                state_r    <= ST_LOAD;
              end
              OP_SUB_PERIOD: begin
                sub_per_r <= quo_nxt;
                op_r      <= OP_BEAT_MOD;
                state_r   <= ST_LOAD;
              end
              OP_BEAT_MOD: begin
                mod_r   <= rem_nxt;
                op_r    <= OP_BEAT_PCT;
                state_r <= ST_LOAD;
              end
              OP_BEAT_PCT: begin
                prog_r  <= quo_nxt[PCT_W-1:0];
                op_r    <= OP_SUB_MOD;
                state_r <= ST_LOAD;
              end
              OP_SUB_MOD: begin
                mod_r   <= rem_nxt;
                op_r    <= OP_SUB_PCT;
                state_r <= ST_LOAD;
              end
              OP_SUB_PCT: begin
                sprog_r <= quo_nxt[PCT_W-1:0];
                state_r <= ST_DONE;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end

        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            last_prog_r       <= prog_r;
            beat_r            <= beat_nxt;
            sub_pos_r         <= sub_pos_nxt;
            out_valid_r       <= 1'b1;
            out_event_code    <= event_nxt;
            out_beat_count    <= beat_nxt;
            out_sub_index     <= sub_pos_nxt;
            out_beat_progress <= prog_r;
            out_sub_progress  <= sprog_r;
            out_sub_count     <= subs_eff;
            if (beat_nxt[BEAT_W-1]) begin
              out_beat_in_bar <= beat_nxt[2:0];
              out_bar_count   <= '0;
            end else begin
              out_beat_in_bar <= {1'b0, beat_nxt[1:0]};
              out_bar_count   <= beat_nxt[BAR_W+1:2];
            end
            state_r <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
